FILE: sv/edd_pkg.sv
// Shared constants and types for the integer Euclidean distance core.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package edd_pkg;

  localparam int DEFAULT_COORD_WIDTH = 24;
  // Depth of the queue between the difference front end and the root back end.
  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: sv/euclidean_distance_isqrt_core.sv
// Integer Euclidean distance: floor(sqrt(dx^2 + dy^2 [+ dh^2])).
// Throughput: one command per cycle; the root is a COORD_WIDTH + 1 stage pipeline
// and the result port cannot stall, so busy only rises if the queue fills.
// Reset (synchronous, rst high) clears all valid flags and the queue; data is not cleared.
`timescale 1ns / 1ps

module euclidean_distance_isqrt_core #(
  parameter int COORD_WIDTH = edd_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_h,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_h,
  output logic [COORD_WIDTH:0]          distance,
  output logic                          done
);

  logic                     push;
  logic [3*COORD_WIDTH-1:0] push_data;
  logic [3*COORD_WIDTH-1:0] pop_data;
  edd_pkg::fifo_stat_t      stat;
  logic                     pop;

  // back end never stalls, so it drains the queue whenever there is a transfer waiting
  assign pop = !stat.empty;

  edd_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .first_x  (first_x),
    .first_y  (first_y),
    .first_h  (first_h),
    .second_x (second_x),
    .second_y (second_y),
    .second_h (second_h),
    .stat     (stat),
    .push     (push),
    .push_data(push_data)
  );

  edd_fifo #(
    .DATA_WIDTH(3 * COORD_WIDTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .stat     (stat)
  );

  edd_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(pop),
    .in_data (pop_data),
    .distance(distance),
    .done    (done)
  );

endmodule

FILE: sv/edd_front.sv
// Front end: takes a command, forms per-axis absolute differences.
// Depends on edd_pkg (queue status struct).
`timescale 1ns / 1ps

module edd_front #(
  parameter int COORD_WIDTH = edd_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       op,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_h,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_h,
  input  edd_pkg::fifo_stat_t        stat,
  output logic                       push,
  output logic [3*COORD_WIDTH-1:0]   push_data
);

  logic                   held;
  logic [COORD_WIDTH-1:0] ax;
  logic [COORD_WIDTH-1:0] ay;
  logic [COORD_WIDTH-1:0] ah;
  logic [COORD_WIDTH-1:0] ax_next;
  logic [COORD_WIDTH-1:0] ay_next;
  logic [COORD_WIDTH-1:0] ah_next;
  logic                   take;

  function automatic logic [COORD_WIDTH-1:0] abs_diff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [COORD_WIDTH:0] d;
    logic        [COORD_WIDTH:0] m;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    m = d[COORD_WIDTH] ? -d : d;
    return m[COORD_WIDTH-1:0];
  endfunction

  assign push      = held && !stat.full;
  assign busy      = held && stat.full;
  assign take      = start && !busy;
  assign push_data = {ax, ay, ah};

  always_comb begin
    ax_next = abs_diff(first_x, second_x);
    ay_next = abs_diff(first_y, second_y);
    // horizontal mode drops the height axis
    ah_next = op ? '0 : abs_diff(first_h, second_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ax <= ax_next;
      ay <= ay_next;
      ah <= ah_next;
    end
  end

endmodule

FILE: sv/edd_fifo.sv
// Short show-ahead queue decoupling the front end from the back end.
// Depends on edd_pkg (depth, status struct).
`timescale 1ns / 1ps

module edd_fifo #(
  parameter int DATA_WIDTH = 3 * edd_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] pop_data,
  output edd_pkg::fifo_stat_t   stat
);

  localparam int Depth = edd_pkg::FIFO_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [DATA_WIDTH-1:0] mem [0:Depth-1];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;
  logic                  do_push;
  logic                  do_pop;

  assign stat.full  = (count == CntW'(Depth));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/edd_back.sv
// Back end: squares, sum, and a pipelined digit-by-digit integer square root.
// Depends on edd_pkg (default coordinate width); widths follow COORD_WIDTH.
`timescale 1ns / 1ps

module edd_back #(
  parameter int COORD_WIDTH = edd_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [3*COORD_WIDTH-1:0] in_data,
  output logic [COORD_WIDTH:0]     distance,
  output logic                     done
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int SW = 2 * COORD_WIDTH + 2;
  localparam int RW = DW + 2;
  localparam int QW = 2 * COORD_WIDTH;

  logic          sq_vld;
  logic [QW-1:0] sq_x;
  logic [QW-1:0] sq_y;
  logic [QW-1:0] sq_h;

  logic          vld  [0:DW];
  logic [SW-1:0] rad  [0:DW];
  logic [RW-1:0] rem  [0:DW];
  logic [DW-1:0] root [0:DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
      vld[0] <= 1'b0;
    end else begin
      sq_vld <= in_valid;
      vld[0] <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_x    <= QW'(in_data[3*COORD_WIDTH-1:2*COORD_WIDTH]) *
               QW'(in_data[3*COORD_WIDTH-1:2*COORD_WIDTH]);
    sq_y    <= QW'(in_data[2*COORD_WIDTH-1:COORD_WIDTH]) *
               QW'(in_data[2*COORD_WIDTH-1:COORD_WIDTH]);
    sq_h    <= QW'(in_data[COORD_WIDTH-1:0]) * QW'(in_data[COORD_WIDTH-1:0]);
    rad[0]  <= SW'(sq_x) + SW'(sq_y) + SW'(sq_h);
    rem[0]  <= '0;
    root[0] <= '0;
  end

  // One result bit per stage, two radicand bits consumed per stage.
  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;

    always_comb begin
      rem_sh = {rem[k], rad[k][SW-1:SW-2]};
      trial  = {2'b00, root[k], 2'b01};
      diff   = rem_sh - trial;
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rad[k+1]  <= {rad[k][SW-3:0], 2'b00};
      rem[k+1]  <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
      root[k+1] <= {root[k][DW-2:0], ge};
    end
  end

  assign distance = root[DW];
  assign done     = vld[DW];

endmodule
